// ===== design/sfp_pkg.sv =====
// shared types, constants and helper functions for the fingerprint text parser
package sfp_pkg;

  localparam int unsigned DIGEST_BYTES = 32;
  localparam int unsigned FULL_DIGITS  = 2 * DIGEST_BYTES;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned INDEX_W      = 5;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(FULL_DIGITS);
  localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_W'(FULL_DIGITS + 1);
  localparam logic [COUNT_W-2:0] BYTE_LIMIT = (COUNT_W-1)'(DIGEST_BYTES);

  localparam logic [2:0] PREFIX_LEN = 3'd7;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_DIGEST = 2'd1,
    PH_FAILED = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         prefix_position;
    logic               prefix_mismatch;
    logic               expect_high_half;
    logic [3:0]         held_nibble;
    logic [COUNT_W-1:0] digit_count;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:            PH_PREFIX,
    prefix_position:  3'd0,
    prefix_mismatch:  1'b0,
    expect_high_half: 1'b1,
    held_nibble:      4'd0,
    digit_count:      '0
  };

  typedef struct packed {
    logic               byte_valid;
    logic [7:0]         digest_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               done_res;
    logic               ok;
  } parse_result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  // expected lower-case prefix "sha-256"
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h73;
      3'd1:    ch = 8'h68;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h2d;
      3'd4:    ch = 8'h32;
      3'd5:    ch = 8'h35;
      3'd6:    ch = 8'h36;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n.valid = 1'b1;
      n.value = 4'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      n.valid = 1'b1;
      n.value = 4'(c - CH_LOWER_A + 8'd10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      n.valid = 1'b1;
      n.value = 4'(c - CH_UPPER_A + 8'd10);
    end
    return n;
  endfunction

endpackage

// ===== design/sfp_step.sv =====
// next-state and result logic for one character of the fingerprint string
module sfp_step (
  input  sfp_pkg::parse_state_t  state,
  input  logic [7:0]             text_char,
  input  logic                   last_char,
  output sfp_pkg::parse_state_t  state_next,
  output sfp_pkg::parse_result_t result
);

  sfp_pkg::parse_state_t       s;
  sfp_pkg::nibble_t            nib;
  logic [7:0]                  folded;
  logic [sfp_pkg::COUNT_W-2:0] pair_index;

  assign nib        = sfp_pkg::hex_nibble(text_char);
  assign folded     = (text_char >= sfp_pkg::CH_UPPER_A && text_char <= sfp_pkg::CH_UPPER_Z)
                      ? text_char + sfp_pkg::CASE_SHIFT : text_char;
  assign pair_index = state.digit_count[sfp_pkg::COUNT_W-1:1];

  always_comb begin
    s      = state;
    result = '0;
    unique case (state.phase)
      sfp_pkg::PH_PREFIX: begin
        if (text_char == sfp_pkg::CH_SPACE) begin
          if (state.prefix_position == sfp_pkg::PREFIX_LEN && !state.prefix_mismatch) begin
            s.phase = sfp_pkg::PH_DIGEST;
          end else begin
            s.phase = sfp_pkg::PH_FAILED;
          end
        end else if (state.prefix_position < sfp_pkg::PREFIX_LEN) begin
          if (folded != sfp_pkg::prefix_char(state.prefix_position)) begin
            s.prefix_mismatch = 1'b1;
          end
          s.prefix_position = state.prefix_position + 3'd1;
        end else begin
          s.prefix_mismatch = 1'b1;
        end
      end
      sfp_pkg::PH_DIGEST: begin
        if (text_char != sfp_pkg::CH_COLON) begin
          if (!nib.valid) begin
            s.phase = sfp_pkg::PH_FAILED;
          end else begin
            if (state.expect_high_half) begin
              s.held_nibble      = nib.value;
              s.expect_high_half = 1'b0;
            end else begin
              // bytes past the digest length are dropped
              if (pair_index < sfp_pkg::BYTE_LIMIT) begin
                result.byte_valid  = 1'b1;
                result.digest_byte = {state.held_nibble, nib.value};
                result.byte_index  = pair_index[sfp_pkg::INDEX_W-1:0];
              end
              s.expect_high_half = 1'b1;
            end
            if (state.digit_count < sfp_pkg::COUNT_SAT) begin
              s.digit_count = state.digit_count + sfp_pkg::COUNT_W'(1);
            end
          end
        end
      end
      default: begin
        // failed phase holds until the last character
      end
    endcase

    if (last_char) begin
      result.done_res = 1'b1;
      result.ok       = s.phase == sfp_pkg::PH_DIGEST && s.expect_high_half
                        && s.digit_count == sfp_pkg::COUNT_FULL;
      s               = sfp_pkg::STATE_RESET;
    end
    state_next = s;
  end

endmodule

// ===== design/sha256_fingerprint_text_parser_core.sv =====
// top level: input register, per-character parse step and result register
// an accepted character passes the input register and then the result register to the output
// throughput: one character per cycle when not stalled; the input register holds one extra item
//   while the result register is stalled
// reset: synchronous, clears both valid flags and returns the parser to the prefix phase
module sha256_fingerprint_text_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_char,
  input  logic       last_char,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       byte_valid,
  output logic [7:0] digest_byte,
  output logic [4:0] byte_index,
  output logic       done_res,
  output logic       ok
);

  logic                   in_full;
  logic [7:0]             in_char;
  logic                   in_last;
  logic                   advance;
  sfp_pkg::parse_state_t  state;
  sfp_pkg::parse_state_t  state_next;
  sfp_pkg::parse_result_t step_res;
  sfp_pkg::parse_result_t res;

  // the held item moves on when the result register is empty or being drained
  assign advance    = in_full && (!res_valid || !res_stall);
  assign text_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!text_stall) begin
      in_full <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_char <= text_char;
      in_last <= last_char;
    end
  end

  sfp_step u_step (
    .state      (state),
    .text_char  (in_char),
    .last_char  (in_last),
    .state_next (state_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign byte_valid  = res.byte_valid;
  assign digest_byte = res.digest_byte;
  assign byte_index  = res.byte_index;
  assign done_res    = res.done_res;
  assign ok          = res.ok;

endmodule

// ===== design/sfp_checker.sv =====
// port-level checks for the fingerprint text parser and their binding
module sfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic       byte_valid,
  input logic [7:0] digest_byte,
  input logic [4:0] byte_index,
  input logic       done_res,
  input logic       ok
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> !ok)
    else $error("ok reported before the last character");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !byte_valid |-> digest_byte == 8'd0 && byte_index == 5'd0)
    else $error("byte fields set without a completed byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(byte_valid) && $stable(digest_byte)
      && $stable(byte_index) && $stable(done_res) && $stable(ok))
    else $error("result changed while stalled");

endmodule

bind sha256_fingerprint_text_parser_core sfp_checker u_sfp_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .byte_valid  (byte_valid),
  .digest_byte (digest_byte),
  .byte_index  (byte_index),
  .done_res    (done_res),
  .ok          (ok)
);

// ===== sim/testbench.sv =====
// testbench for the fingerprint text parser: directed table, random strings, scoreboard
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [55:0] PREFIX_TEXT = "sha-256";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       bv;
    logic [7:0] db;
    logic [4:0] bi;
    logic       dn;
    logic       okv;
  } char_row_t;

  // rows with typed set carry a result that is obvious at a glance
  localparam char_row_t DIRECTED_ROWS [19] = '{
    '{"x",   1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1, 1'b0},
    '{" ",   1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1, 1'b0},
    '{"s",   1'b0, 1'b1, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{" ",   1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1, 1'b0},
    '{"S",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"H",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"A",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"-",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"2",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"5",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"6",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{" ",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"f",   1'b0, 1'b1, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"F",   1'b0, 1'b1, 1'b1, 8'hff, 5'd0, 1'b0, 1'b0},
    '{":",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"0",   1'b0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0, 1'b0},
    '{"0",   1'b0, 1'b1, 1'b1, 8'h00, 5'd1, 1'b0, 1'b0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1, 1'b0}
  };

  logic       clk;
  logic       rst;
  logic       text_valid;
  logic       text_stall;
  logic [7:0] text_char;
  logic       last_char;
  logic       res_valid;
  logic       res_stall;
  logic       byte_valid;
  logic [7:0] digest_byte;
  logic [4:0] byte_index;
  logic       done_res;
  logic       ok;

  // parser state mirror
  sfp_pkg::phase_t ph;
  logic [2:0]      pfx_pos;
  logic            pfx_bad;
  logic            want_high;
  logic [3:0]      held;
  logic [6:0]      digits;

  sfp_pkg::parse_result_t parse_results_q[$];
  sfp_pkg::parse_result_t next_result;
  int unsigned            items_sent;
  int unsigned            mismatch_count;
  int unsigned            cycle_count;
  int unsigned            send_gap_pct;
  int unsigned            recv_stall_pct;
  int unsigned            hold_requests;
  int unsigned            holds_served;
  int unsigned            hold_left;

  sha256_fingerprint_text_parser_core u_top (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_char   (text_char),
    .last_char   (last_char),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .byte_valid  (byte_valid),
    .digest_byte (digest_byte),
    .byte_index  (byte_index),
    .done_res    (done_res),
    .ok          (ok)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_parser();
    ph        = sfp_pkg::PH_PREFIX;
    pfx_pos   = 3'd0;
    pfx_bad   = 1'b0;
    want_high = 1'b1;
    held      = 4'd0;
    digits    = '0;
  endfunction

  function automatic sfp_pkg::parse_result_t parse_char(input logic [7:0] c, input logic last);
    sfp_pkg::parse_result_t r;
    logic [7:0]             lc;
    int                     nib;
    int unsigned            k;
    r = '0;
    case (ph)
      sfp_pkg::PH_PREFIX: begin
        if (c == sfp_pkg::CH_SPACE) begin
          ph = (pfx_pos == sfp_pkg::PREFIX_LEN && !pfx_bad)
               ? sfp_pkg::PH_DIGEST : sfp_pkg::PH_FAILED;
        end else if (pfx_pos < sfp_pkg::PREFIX_LEN) begin
          // only A..Z fold to lower case
          lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
          if (lc != PREFIX_TEXT[8*(6-pfx_pos) +: 8]) pfx_bad = 1'b1;
          pfx_pos = pfx_pos + 3'd1;
        end else begin
          pfx_bad = 1'b1;
        end
      end
      sfp_pkg::PH_DIGEST: begin
        if (c != sfp_pkg::CH_COLON) begin
          if (c >= "0" && c <= "9") nib = c - "0";
          else if (c >= "a" && c <= "f") nib = c - "a" + 10;
          else if (c >= "A" && c <= "F") nib = c - "A" + 10;
          else nib = -1;
          if (nib < 0) begin
            ph = sfp_pkg::PH_FAILED;
          end else begin
            if (want_high) begin
              held = nib[3:0];
              want_high = 1'b0;
            end else begin
              k = digits >> 1;
              if (k < sfp_pkg::DIGEST_BYTES) begin
                r.byte_valid  = 1'b1;
                r.digest_byte = {held, nib[3:0]};
                r.byte_index  = k[4:0];
              end
              want_high = 1'b1;
            end
            if (digits < sfp_pkg::COUNT_SAT) digits = digits + 7'd1;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      r.done_res = 1'b1;
      r.ok = (ph == sfp_pkg::PH_DIGEST && want_high && digits == sfp_pkg::COUNT_FULL);
      reset_parser();
    end
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic offer_char(input logic [7:0] c, input logic last, input logic use_typed,
                            input sfp_pkg::parse_result_t typed_res);
    sfp_pkg::parse_result_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      text_valid = 1'b0;
      @(negedge clk);
    end
    text_valid = 1'b1;
    text_char  = c;
    last_char  = last;
    do @(posedge clk); while (text_stall);
    predicted = parse_char(c, last);
    parse_results_q.insert(parse_results_q.size(), use_typed ? typed_res : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_fingerprint();
    logic [7:0]  text_q[$];
    logic [7:0]  ch;
    logic [3:0]  nib;
    int unsigned kind;
    int unsigned ndig;
    int unsigned colon_mode;
    int unsigned len;
    kind = $urandom_range(99);
    if (kind < 80) begin
      for (int i = 0; i < 7; i++) begin
        ch = PREFIX_TEXT[8*(6-i) +: 8];
        if (ch >= "a" && ch <= "z" && $urandom_range(1) == 1) ch = ch - 8'd32;
        text_q.insert(text_q.size(), ch);
      end
      text_q.insert(text_q.size(), sfp_pkg::CH_SPACE);
      // mostly a full digest, otherwise any count up to past saturation
      ndig = ($urandom_range(2) != 0) ? 2 * sfp_pkg::DIGEST_BYTES : $urandom_range(70);
      colon_mode = $urandom_range(2);
      for (int i = 0; i < ndig; i++) begin
        nib = 4'($urandom);
        if (nib < 4'd10) ch = sfp_pkg::CH_ZERO + 8'(nib);
        else ch = ($urandom_range(1) == 1 ? sfp_pkg::CH_LOWER_A : sfp_pkg::CH_UPPER_A)
                  + 8'(nib) - 8'd10;
        text_q.insert(text_q.size(), ch);
        if ((colon_mode == 1 && i % 2 == 1 && i != ndig - 1) ||
            (colon_mode == 2 && $urandom_range(3) == 0))
          text_q.insert(text_q.size(), sfp_pkg::CH_COLON);
      end
      // corrupt one character
      if (kind >= 60) text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
    end else if (kind < 90) begin
      // prefix near misses: wrong length, wrong character, missing space
      len = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
        if (i < 7 && $urandom_range(3) != 0) ch = PREFIX_TEXT[8*(6-i) +: 8];
        else ch = 8'($urandom);
        text_q.insert(text_q.size(), ch);
      end
      if ($urandom_range(3) != 0) text_q.insert(text_q.size(), sfp_pkg::CH_SPACE);
      len = $urandom_range(4);
      for (int i = 0; i < len; i++)
        text_q.insert(text_q.size(), sfp_pkg::CH_ZERO + 8'($urandom_range(9)));
    end else begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) text_q.insert(text_q.size(), 8'($urandom));
    end
    if (text_q.size() == 0) text_q.insert(0, 8'($urandom));
    foreach (text_q[i]) offer_char(text_q[i], i == text_q.size() - 1, 1'b0, '0);
  endtask

  // receiver: random stalls plus a long hold-off on request
  initial begin
    res_stall    = 1'b0;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall = 1'b1;
        hold_left--;
      end else begin
        res_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp,
                                      input logic [7:0] act);
    if (exp !== act) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (parse_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, expected none, actual %0h/%0h/%0h/%0h/%0h",
                 $time, byte_valid, digest_byte, byte_index, done_res, ok);
      end else begin
        next_result = parse_results_q.pop_front();
        check_field("byte_valid", next_result.byte_valid, byte_valid);
        check_field("digest_byte", next_result.digest_byte, digest_byte);
        check_field("byte_index", next_result.byte_index, byte_index);
        check_field("done_res", next_result.done_res, done_res);
        check_field("ok", next_result.ok, ok);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sha256_fingerprint_text_parser_core test failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    text_valid     = 1'b0;
    text_char      = 8'h00;
    last_char      = 1'b0;
    items_sent     = 0;
    mismatch_count = 0;
    hold_requests  = 0;
    send_gap_pct   = 12;
    recv_stall_pct = 49;
    reset_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_ROWS[i])
      offer_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                 {DIRECTED_ROWS[i].bv, DIRECTED_ROWS[i].db, DIRECTED_ROWS[i].bi,
                  DIRECTED_ROWS[i].dn, DIRECTED_ROWS[i].okv});
    while (items_sent < 430) send_random_fingerprint();

    // sender pauses until the pipe has drained
    text_valid = 1'b0;
    while (parse_results_q.size() != 0) @(negedge clk);

    send_gap_pct   = 49;
    recv_stall_pct = 12;
    while (items_sent < 870) send_random_fingerprint();

    // no idling, but the receiver holds off long enough to back up the input
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_requests++;
    while (items_sent < 1300) send_random_fingerprint();

    text_valid = 1'b0;
    while (parse_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("sha256_fingerprint_text_parser_core test passed");
    end else begin
      $display("sha256_fingerprint_text_parser_core test failed");
    end
    $finish;
  end

endmodule
